FILE: rtl/ltl_pkg.sv
// ----------------------------------------------------------------------------
// ltl_pkg - shared types and constants for the lattice reduction block
// Payload structs of both channels and the widths of the exact-integer
// ratio datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ltl_pkg;

	// one input transfer: three lattice rows, signed Q16.16
	typedef struct packed {
		logic signed [31:0] row0_x;
		logic signed [31:0] row0_y;
		logic signed [31:0] row0_z;
		logic signed [31:0] row1_x;
		logic signed [31:0] row1_y;
		logic signed [31:0] row1_z;
		logic signed [31:0] row2_x;
		logic signed [31:0] row2_y;
		logic signed [31:0] row2_z;
	} in_t;

	// one result transfer: lower-triangular entries, signed Q16.16
	typedef struct packed {
		logic signed [31:0] out_00;
		logic signed [31:0] out_10;
		logic signed [31:0] out_11;
		logic signed [31:0] out_20;
		logic signed [31:0] out_21;
		logic signed [31:0] out_22;
		logic               degenerate;
	} out_t;

	// numerator (a square, below 2^256) and denominator (below 2^192)
	localparam int NUM_W      = 256;
	localparam int DEN_W      = 192;
	// quotient bits below the cap, and root iterations
	localparam int DIV_BITS   = 62;
	localparam int SQRT_STEPS = 32;
	// registers from ratio inputs to ratio result
	localparam int RATIO_LAT  = DIV_BITS + SQRT_STEPS + 2;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;

endpackage

`default_nettype wire

FILE: rtl/lattice_to_lower_triangular.sv
// ----------------------------------------------------------------------------
// lattice_to_lower_triangular - 3x3 lattice to lower-triangular form
// Exact integer Gram-Schmidt of three Q16.16 rows with saturated outputs.
// ----------------------------------------------------------------------------
// One matrix enters per clock while matrix_ready is high. Ten stages build
// the cross products, dot products and their squares in exact integer form,
// then each of the six entries passes a 96-stage unit made of a 62-step
// restoring divider and a 32-step integer root. An output register with a
// one-entry skid stage lets the pipeline keep accepting while one result
// waits; matrix_ready drops while the skid stage is full. When rows 0 and 1
// are parallel or zero, degenerate is set and all six entries are zero.
`default_nettype none

module lattice_to_lower_triangular (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          matrix_valid,
	output logic               matrix_ready,
	input  wire ltl_pkg::in_t  matrix,
	output logic               result_valid,
	input  wire logic          result_ready,
	output ltl_pkg::out_t      result
);

	localparam int LAT = ltl_pkg::RATIO_LAT;

	typedef struct packed {
		logic signed [67:0] hh;
		logic signed [67:0] hl;
		logic signed [67:0] lh;
		logic signed [67:0] ll;
	} pp_t;

	// split the product of two 66-bit operands into four narrow partial products
	function automatic pp_t pmul(input logic signed [65:0] a, input logic signed [65:0] b);
		logic signed [33:0] ah;
		logic signed [33:0] bh;
		logic signed [32:0] al;
		logic signed [32:0] bl;
		pp_t p;
		ah = a[65:32];
		bh = b[65:32];
		al = {1'b0, a[31:0]};
		bl = {1'b0, b[31:0]};
		p.hh = 68'(ah) * 68'(bh);
		p.hl = 68'(ah) * 68'(bl);
		p.lh = 68'(al) * 68'(bh);
		p.ll = 68'(al) * 68'(bl);
		return p;
	endfunction

	function automatic logic signed [131:0] pjoin(input pp_t p);
		return (132'(p.hh) <<< 64) + ((132'(p.hl) + 132'(p.lh)) <<< 32) + 132'(p.ll);
	endfunction

	// 128-bit value times one 32-bit digit, from four 32x32 partial products
	function automatic logic [159:0] mul_digit(input logic [127:0] a, input logic [31:0] d);
		logic [159:0] acc;
		acc = '0;
		for (int m = 0; m < 4; m++) begin
			acc = acc + (160'(64'(a[32*m +: 32]) * 64'(d)) << (32 * m));
		end
		return acc;
	endfunction

	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en           = !skid_v_q;
	assign matrix_ready = en;

	// stage 1: capture input
	ltl_pkg::in_t in_s1;
	logic         v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= matrix_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= matrix;
		end
	end

	logic signed [31:0] r0 [3];
	logic signed [31:0] r1 [3];
	logic signed [31:0] r2 [3];
	always_comb begin
		r0[0] = in_s1.row0_x; r0[1] = in_s1.row0_y; r0[2] = in_s1.row0_z;
		r1[0] = in_s1.row1_x; r1[1] = in_s1.row1_y; r1[2] = in_s1.row1_z;
		r2[0] = in_s1.row2_x; r2[1] = in_s1.row2_y; r2[2] = in_s1.row2_z;
	end

	// stage 2: all 32x32 products
	logic signed [63:0] cpa_s2 [3];
	logic signed [63:0] cpb_s2 [3];
	logic signed [63:0] dpa_s2 [3];
	logic signed [63:0] dpb_s2 [3];
	logic signed [63:0] sp_s2  [3];
	logic signed [63:0] p01_s2 [3];
	logic signed [63:0] p02_s2 [3];
	logic signed [31:0] r2_s2  [3];
	logic               v_s2;

	for (genvar k = 0; k < 3; k++) begin : g_s2
		localparam int I = (k + 1) % 3;
		localparam int J = (k + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				cpa_s2[k] <= 64'(r0[I]) * 64'(r1[J]);
				cpb_s2[k] <= 64'(r0[J]) * 64'(r1[I]);
				dpa_s2[k] <= 64'(r0[I]) * 64'(r2[J]);
				dpb_s2[k] <= 64'(r0[J]) * 64'(r2[I]);
				sp_s2[k]  <= 64'(r0[k]) * 64'(r0[k]);
				p01_s2[k] <= 64'(r0[k]) * 64'(r1[k]);
				p02_s2[k] <= 64'(r0[k]) * 64'(r2[k]);
				r2_s2[k]  <= r2[k];
			end
		end
	end

	// stage 3: cross products and dot products of rows
	logic signed [64:0] c_s3  [3];
	logic signed [64:0] d_s3  [3];
	logic signed [31:0] r2_s3 [3];
	logic [63:0]        s_s3;
	logic signed [65:0] d01_s3;
	logic signed [65:0] d02_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				c_s3[k]  <= 65'(cpa_s2[k]) - 65'(cpb_s2[k]);
				d_s3[k]  <= 65'(dpa_s2[k]) - 65'(dpb_s2[k]);
				r2_s3[k] <= r2_s2[k];
			end
			s_s3   <= 64'(sp_s2[0]) + 64'(sp_s2[1]) + 64'(sp_s2[2]);
			d01_s3 <= 66'(p01_s2[0]) + 66'(p01_s2[1]) + 66'(p01_s2[2]);
			d02_s3 <= 66'(p02_s2[0]) + 66'(p02_s2[1]) + 66'(p02_s2[2]);
		end
	end

	// stage 4: partial products of the wide terms
	pp_t         ppc_s4 [3];
	pp_t         ppe_s4 [3];
	pp_t         ppd_s4 [3];
	pp_t         pp01_s4;
	pp_t         pp02_s4;
	logic [63:0] s_s4;
	logic        n01_s4, n02_s4;
	logic        v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ppc_s4[k] <= pmul(66'(c_s3[k]), 66'(c_s3[k]));
				ppe_s4[k] <= pmul(66'(c_s3[k]), 66'(d_s3[k]));
				ppd_s4[k] <= pmul(66'(r2_s3[k]), 66'(c_s3[k]));
			end
			pp01_s4 <= pmul(d01_s3, d01_s3);
			pp02_s4 <= pmul(d02_s3, d02_s3);
			s_s4    <= s_s3;
			n01_s4  <= d01_s3[65];
			n02_s4  <= d02_s3[65];
		end
	end

	// stage 5: join partial products
	logic signed [131:0] tc_s5 [3];
	logic signed [131:0] te_s5 [3];
	logic signed [131:0] td_s5 [3];
	logic signed [131:0] sq01_s5;
	logic signed [131:0] sq02_s5;
	logic [63:0]         s_s5;
	logic                n01_s5, n02_s5;
	logic                v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				tc_s5[k] <= pjoin(ppc_s4[k]);
				te_s5[k] <= pjoin(ppe_s4[k]);
				td_s5[k] <= pjoin(ppd_s4[k]);
			end
			sq01_s5 <= pjoin(pp01_s4);
			sq02_s5 <= pjoin(pp02_s4);
			s_s5    <= s_s4;
			n01_s5  <= n01_s4;
			n02_s5  <= n02_s4;
		end
	end

	// stage 6: sums to magnitudes and signs; arrays index the stage
	logic signed [131:0] esum, dsum, csum;
	logic [131:0]        emag, dmag;
	assign csum = tc_s5[0] + tc_s5[1] + tc_s5[2];
	assign esum = te_s5[0] + te_s5[1] + te_s5[2];
	assign dsum = td_s5[0] + td_s5[1] + td_s5[2];
	assign emag = esum[131] ? 132'(0 - esum) : esum;
	assign dmag = dsum[131] ? 132'(0 - dsum) : dsum;

	logic [127:0] ae_s   [6:10];
	logic [127:0] ad_s   [6:10];
	logic [127:0] cc_s   [6:10];
	logic [127:0] sq01_s [6:10];
	logic [127:0] sq02_s [6:10];
	logic [63:0]  s_s    [6:10];
	logic [255:0] sqe_s  [6:10];
	logic [255:0] sqd_s  [6:10];
	logic [255:0] sc_s   [6:10];
	logic         ne_s   [6:10];
	logic         nd_s   [6:10];
	logic         n01_s  [6:10];
	logic         n02_s  [6:10];
	logic         dg_s   [6:10];
	logic         v_s    [6:10];

	always_ff @(posedge clk) begin
		if (en) begin
			ae_s[6]   <= emag[127:0];
			ad_s[6]   <= dmag[127:0];
			cc_s[6]   <= csum[127:0];
			sq01_s[6] <= sq01_s5[127:0];
			sq02_s[6] <= sq02_s5[127:0];
			s_s[6]    <= s_s5;
			sqe_s[6]  <= '0;
			sqd_s[6]  <= '0;
			sc_s[6]   <= '0;
			ne_s[6]   <= esum[131];
			nd_s[6]   <= dsum[131];
			n01_s[6]  <= n01_s5;
			n02_s[6]  <= n02_s5;
			dg_s[6]   <= 1'b0;
		end
	end

	// stages 7-10: one 32-bit digit per stage for e^2, det^2 and s*cc
	for (genvar k = 0; k < 4; k++) begin : g_dig
		localparam int ST = 7 + k;
		logic [31:0] dge, dgd, dgs;
		assign dge = ae_s[ST-1][32*k +: 32];
		assign dgd = ad_s[ST-1][32*k +: 32];
		assign dgs = (k < 2) ? s_s[ST-1][32*(k%2) +: 32] : 32'd0;
		always_ff @(posedge clk) begin
			if (en) begin
				sqe_s[ST]  <= sqe_s[ST-1] + (256'(mul_digit(ae_s[ST-1], dge)) << (32 * k));
				sqd_s[ST]  <= sqd_s[ST-1] + (256'(mul_digit(ad_s[ST-1], dgd)) << (32 * k));
				sc_s[ST]   <= sc_s[ST-1] + (256'(mul_digit(cc_s[ST-1], dgs)) << (32 * k));
				ae_s[ST]   <= ae_s[ST-1];
				ad_s[ST]   <= ad_s[ST-1];
				cc_s[ST]   <= cc_s[ST-1];
				sq01_s[ST] <= sq01_s[ST-1];
				sq02_s[ST] <= sq02_s[ST-1];
				s_s[ST]    <= s_s[ST-1];
				ne_s[ST]   <= ne_s[ST-1];
				nd_s[ST]   <= nd_s[ST-1];
				n01_s[ST]  <= n01_s[ST-1];
				n02_s[ST]  <= n02_s[ST-1];
				dg_s[ST]   <= (k == 0) ? (cc_s[ST-1] == '0) : dg_s[ST-1];
			end
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 6; i <= 10; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s[6] <= v_s5;
			for (int i = 7; i <= 10; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	// six ratio units
	ltl_pkg::num_t     rnum [6];
	ltl_pkg::den_t     rden [6];
	logic              rneg [6];
	logic signed [31:0] rres [6];

	always_comb begin
		rnum[0] = ltl_pkg::NUM_W'(s_s[10]);
		rden[0] = ltl_pkg::DEN_W'(1);
		rneg[0] = 1'b0;
		rnum[1] = ltl_pkg::NUM_W'(sq01_s[10]);
		rden[1] = ltl_pkg::DEN_W'(s_s[10]);
		rneg[1] = n01_s[10];
		rnum[2] = ltl_pkg::NUM_W'(cc_s[10]);
		rden[2] = ltl_pkg::DEN_W'(s_s[10]);
		rneg[2] = 1'b0;
		rnum[3] = ltl_pkg::NUM_W'(sq02_s[10]);
		rden[3] = ltl_pkg::DEN_W'(s_s[10]);
		rneg[3] = n02_s[10];
		rnum[4] = sqe_s[10];
		rden[4] = sc_s[10][ltl_pkg::DEN_W-1:0];
		rneg[4] = ne_s[10];
		rnum[5] = sqd_s[10];
		rden[5] = ltl_pkg::DEN_W'(cc_s[10]);
		rneg[5] = nd_s[10];
	end

	for (genvar c = 0; c < 6; c++) begin : g_ratio
		ltl_ratio u_ratio (
			.clk (clk),
			.en  (en),
			.num (rnum[c]),
			.den (rden[c]),
			.neg (rneg[c]),
			.res (rres[c])
		);
	end

	// valid and degenerate travel beside the ratio units
	logic dv_q [LAT];
	logic dd_q [LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				dv_q[i] <= 1'b0;
			end
		end else if (en) begin
			dv_q[0] <= v_s[10];
			for (int i = 1; i < LAT; i++) begin
				dv_q[i] <= dv_q[i-1];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dd_q[0] <= dg_s[10];
			for (int i = 1; i < LAT; i++) begin
				dd_q[i] <= dd_q[i-1];
			end
		end
	end

	// assemble the finished result; zero the entries of a degenerate frame
	ltl_pkg::out_t fin;
	logic          dgn;
	assign dgn = dd_q[LAT-1];
	always_comb begin
		fin.out_00     = dgn ? '0 : rres[0];
		fin.out_10     = dgn ? '0 : rres[1];
		fin.out_11     = dgn ? '0 : rres[2];
		fin.out_20     = dgn ? '0 : rres[3];
		fin.out_21     = dgn ? '0 : rres[4];
		fin.out_22     = dgn ? '0 : rres[5];
		fin.degenerate = dgn;
	end

	// output register with skid stage
	ltl_pkg::out_t out_q;
	ltl_pkg::out_t skid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || result_ready) begin
			out_v_q <= dv_q[LAT-1];
		end else if (dv_q[LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (result_ready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || result_ready) begin
			out_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	// skid holds a transfer only behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full with output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !result_ready))
		else $error("skid stage filled while output was free");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && result.degenerate) |->
		(result.out_00 == 0 && result.out_11 == 0 && result.out_22 == 0))
		else $error("degenerate result with nonzero entries");

endmodule

`default_nettype wire

FILE: rtl/ltl_ratio.sv
// ----------------------------------------------------------------------------
// ltl_ratio - pipelined signed root of a ratio
// Returns sign * floor(sqrt(num / den)), quotient capped at 2^62, saturated
// to Q16.16. One restoring division bit and one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ltl_ratio (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire ltl_pkg::num_t      num,
	input  wire ltl_pkg::den_t      den,
	input  wire logic               neg,
	output logic signed [31:0]      res
);

	localparam int NB = ltl_pkg::DIV_BITS;
	localparam int SS = ltl_pkg::SQRT_STEPS;

	ltl_pkg::num_t   rem_s [0:NB];
	ltl_pkg::den_t   den_s [0:NB];
	logic [NB-1:0]   quo_s [0:NB];
	logic            cap_s [0:NB];
	logic            neg_s [0:NB+SS];
	logic [63:0]     x_s   [0:SS];
	logic [63:0]     r_s   [0:SS];

	// test the cap and load the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			cap_s[0] <= num >= (ltl_pkg::NUM_W'(den) << NB);
			neg_s[0] <= neg;
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar i = 1; i <= NB; i++) begin : g_div
		ltl_pkg::num_t trial;
		logic          fits;
		assign trial = ltl_pkg::NUM_W'(den_s[i-1]) << (NB - i);
		assign fits  = rem_s[i-1] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? (rem_s[i-1] - trial) : rem_s[i-1];
				quo_s[i] <= quo_s[i-1] | (NB'(fits) << (NB - i));
				den_s[i] <= den_s[i-1];
				cap_s[i] <= cap_s[i-1];
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	// root input: capped quotient
	assign x_s[0] = cap_s[NB] ? (64'(1) << NB) : 64'(quo_s[NB]);
	assign r_s[0] = '0;

	// digit-by-digit integer root, one result bit per stage
	for (genvar j = 1; j <= SS; j++) begin : g_sqrt
		logic [63:0] bitv;
		logic [63:0] trial;
		logic        fits;
		assign bitv  = 64'(1) << (64 - 2 * j);
		assign trial = r_s[j-1] + bitv;
		assign fits  = x_s[j-1] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[j]      <= fits ? (x_s[j-1] - trial) : x_s[j-1];
				r_s[j]      <= fits ? ((r_s[j-1] >> 1) + bitv) : (r_s[j-1] >> 1);
				neg_s[NB+j] <= neg_s[NB+j-1];
			end
		end
	end

	// apply sign and saturate
	logic [31:0] mag;
	assign mag = r_s[SS][31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NB+SS]) begin
				res <= 32'(0 - ((mag > 32'h8000_0000) ? 32'h8000_0000 : mag));
			end else begin
				res <= (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
			end
		end
	end

endmodule

`default_nettype wire

FILE: verif/ltl_checker.sv
// ----------------------------------------------------------------------------
// ltl_checker - result predictor and scoreboard for the lattice reduction
// Watches both channels, computes the lower-triangular entries of every
// accepted matrix with wide exact integers, and compares each accepted
// result against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module ltl_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          matrix_valid,
	input  wire logic          matrix_ready,
	input  wire ltl_pkg::in_t  matrix,
	input  wire logic          result_valid,
	input  wire logic          result_ready,
	input  wire ltl_pkg::out_t result,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [319:0] wide_t;
	typedef logic [319:0]        mag_t;

	ltl_pkg::out_t triangle_q[$];

	// integer square root of a 64-bit value, bit by bit
	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(num/den), capped at 2^62
	function automatic logic [63:0] capped_quot(mag_t num, mag_t den);
		mag_t q;
		if (num >= (den << 62))
			return 64'd1 << 62;
		q = num / den;
		return q[63:0];
	endfunction

	// clamp a signed magnitude to the Q16.16 range
	function automatic logic [31:0] clamp_q16(logic neg, logic [63:0] m);
		if (neg) begin
			if (m > 64'h8000_0000) m = 64'h8000_0000;
			return 32'(-m);
		end
		if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
		return m[31:0];
	endfunction

	// sign(n) * floor(sqrt(n^2 / den))
	function automatic logic [31:0] signed_ratio(wide_t n, wide_t den);
		mag_t m;
		m = (n < 0) ? mag_t'(-n) : mag_t'(n);
		return clamp_q16(n < 0, root64(capped_quot(m * m, mag_t'(den))));
	endfunction

	function automatic ltl_pkg::out_t reduce_lattice(ltl_pkg::in_t m);
		ltl_pkg::out_t o;
		wide_t a0, a1, a2, b0, b1, b2, g0, g1, g2;
		wide_t c0, c1, c2, d0, d1, d2;
		wide_t s, cc, d01, d02, e, det;
		a0 = wide_t'(m.row0_x); a1 = wide_t'(m.row0_y); a2 = wide_t'(m.row0_z);
		b0 = wide_t'(m.row1_x); b1 = wide_t'(m.row1_y); b2 = wide_t'(m.row1_z);
		g0 = wide_t'(m.row2_x); g1 = wide_t'(m.row2_y); g2 = wide_t'(m.row2_z);
		c0 = a1 * b2 - a2 * b1;
		c1 = a2 * b0 - a0 * b2;
		c2 = a0 * b1 - a1 * b0;
		cc = c0 * c0 + c1 * c1 + c2 * c2;
		o = '0;
		if (cc == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		s   = a0 * a0 + a1 * a1 + a2 * a2;
		d01 = a0 * b0 + a1 * b1 + a2 * b2;
		d02 = a0 * g0 + a1 * g1 + a2 * g2;
		d0  = a1 * g2 - a2 * g1;
		d1  = a2 * g0 - a0 * g2;
		d2  = a0 * g1 - a1 * g0;
		e   = c0 * d0 + c1 * d1 + c2 * d2;
		det = g0 * c0 + g1 * c1 + g2 * c2;
		o.out_00 = clamp_q16(1'b0, root64(capped_quot(mag_t'(s), mag_t'(1))));
		o.out_10 = signed_ratio(d01, s);
		o.out_11 = clamp_q16(1'b0, root64(capped_quot(mag_t'(cc), mag_t'(s))));
		o.out_20 = signed_ratio(d02, s);
		o.out_21 = signed_ratio(e, s * cc);
		o.out_22 = signed_ratio(det, cc);
		return o;
	endfunction

	initial fail_count = 0;
	assign pending = triangle_q.size();

	// predict on input transfers, compare on result transfers
	always @(posedge clk) begin
		ltl_pkg::out_t want;
		if (arst_n) begin
			if (matrix_valid && matrix_ready)
				triangle_q.push_back(reduce_lattice(matrix));
			if (result_valid && result_ready) begin
				if (triangle_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $realtime, result);
					fail_count <= fail_count + 1;
				end else begin
					want = triangle_q.pop_front();
					if (want !== result) begin
						$display("%0t: mismatch expected %h actual %h", $realtime,
							want, result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

FILE: verif/tb_lattice_to_lower_triangular.sv
// ----------------------------------------------------------------------------
// tb_lattice_to_lower_triangular - testbench for the lattice reduction block
// Drives directed and random 3x3 matrices with random gaps and result
// stalls; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lattice_to_lower_triangular;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM  = 1500;
	localparam int CYCLE_CAP = 200000;
	localparam int DRAIN     = 200;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          matrix_valid = 1'b0;
	logic          matrix_ready;
	ltl_pkg::in_t  matrix = '0;
	logic          result_valid;
	logic          result_ready = 1'b0;
	ltl_pkg::out_t result;
	int            fail_count;
	int            pending;
	int            cycles = 0;
	int            stall_left = 0;
	logic          no_idle = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lattice_to_lower_triangular DUT (
		.clk(clk), .arst_n(arst_n),
		.matrix_valid(matrix_valid), .matrix_ready(matrix_ready), .matrix(matrix),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	ltl_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.matrix_valid(matrix_valid), .matrix_ready(matrix_ready), .matrix(matrix),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stall the result side, drawing a new stall per transfer
	always @(posedge clk) begin
		if (result_valid && result_ready)
			stall_left = no_idle ? 0 : $urandom_range(0, 4);
		else if (stall_left > 0)
			stall_left = stall_left - 1;
		result_ready <= (stall_left == 0);
	end

	task automatic send_matrix(ltl_pkg::in_t m);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			matrix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		matrix       <= m;
		matrix_valid <= 1'b1;
		do @(posedge clk); while (!matrix_ready);
	endtask

	function automatic logic [31:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	function automatic ltl_pkg::in_t random_matrix();
		ltl_pkg::in_t m;
		int           mode;
		int           k;
		mode = $urandom_range(0, 3);
		m = {pick_value(mode), pick_value(mode), pick_value(mode),
			pick_value(mode), pick_value(mode), pick_value(mode),
			pick_value(mode), pick_value(mode), pick_value(mode)};
		// make rows 0 and 1 parallel now and then
		if ($urandom_range(0, 9) == 0) begin
			k = $signed($urandom_range(0, 6)) - 3;
			m.row0_x = $signed($urandom_range(0, 4000)) - 2000;
			m.row0_y = $signed($urandom_range(0, 4000)) - 2000;
			m.row0_z = $signed($urandom_range(0, 4000)) - 2000;
			m.row1_x = m.row0_x * k;
			m.row1_y = m.row0_y * k;
			m.row1_z = m.row0_z * k;
		end
		return m;
	endfunction

	initial begin
		ltl_pkg::in_t m;
		int           waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zeros, identity, extremes, degenerate frames
		send_matrix('0);
		send_matrix({32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
			32'h0, 32'h0, 32'h10000});
		send_matrix({32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
			32'h0, 32'h0, 32'hFFFF0000});
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000});
		send_matrix({32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6});
		send_matrix({32'h1, 32'h2, 32'h3, 32'h0, 32'h0, 32'h0, 32'h4, 32'h5, 32'h6});
		send_matrix({32'h1, 32'h2, 32'h3, 32'hFFFF_FFFE, 32'hFFFF_FFFC,
			32'hFFFF_FFFA, 32'h7, 32'h8, 32'h9});
		send_matrix({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_matrix({32'h1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h0,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
		send_matrix({32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
			32'h0, 32'h0, 32'h1});
		send_matrix({32'h10000, 32'h10000, 32'h0, 32'hFFFF0000, 32'h10000, 32'h0,
			32'h30000, 32'hFFFD0000, 32'h50000});

		// random matrices, with bursts free of idling
		for (int i = 0; i < N_RANDOM; i++) begin
			no_idle = ((i / 150) % 4) == 3;
			if (i == N_RANDOM / 2) begin
				// hold off until the pipeline has emptied
				matrix_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			m = random_matrix();
			send_matrix(m);
		end
		matrix_valid <= 1'b0;
		no_idle = 1'b0;

		while (pending != 0) @(posedge clk);
		waited = 0;
		while (waited < DRAIN) begin
			@(posedge clk);
			waited++;
		end
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire

FILE: lattice_to_lower_triangular.f
rtl/ltl_pkg.sv
rtl/ltl_ratio.sv
rtl/lattice_to_lower_triangular.sv
verif/ltl_checker.sv
verif/tb_lattice_to_lower_triangular.sv
